[hw/rtl/ppr_pkg.sv]
// ppr_pkg: shared types, codes and character constants of the pattern-to-regex translator.
// No dependencies; ppr_datapath, ppr_ctrl and prosite_pattern_to_regex refer to it by scoped names.
package ppr_pkg;

  localparam int BUF_DEPTH_DEF = 32;
  localparam int CNT_W         = 16;
  localparam int BCNT_W        = 6;
  localparam int EXT_W         = 7;

  localparam logic [BCNT_W-1:0] BCNT_MAX = 6'd63;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CARET  = 8'h5E; // ^
  localparam logic [7:0] CH_DOLLAR = 8'h24; // $
  localparam logic [7:0] CH_BAR    = 8'h7C; // |
  localparam logic [7:0] CH_DOT    = 8'h2E; // .
  localparam logic [7:0] CH_LT     = 8'h3C; // <
  localparam logic [7:0] CH_GT     = 8'h3E; // >
  localparam logic [7:0] CH_LBRK   = 8'h5B; // [
  localparam logic [7:0] CH_RBRK   = 8'h5D; // ]
  localparam logic [7:0] CH_LBRC   = 8'h7B; // {
  localparam logic [7:0] CH_RBRC   = 8'h7D; // }
  localparam logic [7:0] CH_LPAR   = 8'h28; // (
  localparam logic [7:0] CH_RPAR   = 8'h29; // )
  localparam logic [7:0] CH_COMMA  = 8'h2C; // ,
  localparam logic [7:0] CH_DASH   = 8'h2D; // -
  localparam logic [7:0] CH_X      = 8'h78; // x
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  typedef enum logic [3:0] {
    PS_ERR, PS_START, PS_AFTER_CARET, PS_AFTER_DOLLAR,
    PS_BR_OPEN, PS_BR_IN, PS_BR_CTERM,
    PS_NEG_OPEN, PS_NEG_IN,
    PS_REP_OPEN, PS_REP_LO, PS_REP_COMMA, PS_REP_HI,
    PS_ATOM, PS_DONE, PS_BR_DONE
  } parse_state_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_EMIT2, CS_RD_ISSUE, CS_RD_WAIT, CS_DOLLAR, CS_TERM
  } ctl_state_t;

  typedef enum logic [2:0] {
    PUSH_NONE, PUSH_E0, PUSH_E1, PUSH_BAR, PUSH_MEM, PUSH_DOLLAR, PUSH_TERM
  } push_sel_t;

  typedef struct packed {
    logic      step;   // consume the offered character
    logic      rd;     // read store at replay pointer
    push_sel_t push;   // load output register from this source
  } cmd_t;

  typedef struct packed {
    logic [1:0] emit_cnt;  // characters the offered symbol emits
    logic       replay;    // end marker needs bar, replay and dollar
    logic       more;      // replay pointer below replay length
    logic       slot_free; // output register can take a beat
  } sts_t;

  function automatic logic is_residue(input logic [7:0] c);
    return c >= CH_A && c <= CH_Z && c != CH_J && c != CH_O && c != CH_U;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

endpackage

[hw/rtl/ppr_intf.sv]
// ppr_intf: valid/ready channel interfaces for pattern characters and regex results.
// Depends on nothing.
interface ppr_pattern_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_pattern;
  modport source (output valid, output symbol, output end_of_pattern, input ready);
  modport sink (input valid, input symbol, input end_of_pattern, output ready);
endinterface

interface ppr_regex_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        is_last;
  logic        status;
  logic [15:0] error_position;
  modport source (output valid, output out_char, output is_last, output status,
                  output error_position, input ready);
  modport sink (input valid, input out_char, input is_last, input status,
                input error_position, output ready);
endinterface

[hw/rtl/ppr_datapath.sv]
// ppr_datapath: grammar decode, pattern state, output store and output register.
// Depends on ppr_pkg; driven by ppr_ctrl through cmd_t / sts_t.
module ppr_datapath #(
  parameter int BUF_DEPTH = ppr_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          symbol,
  input  ppr_pkg::cmd_t       cmd,
  output ppr_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                is_last,
  output logic                status,
  output logic [15:0]         error_position
);

  localparam int LEN_W  = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W = $clog2(BUF_DEPTH);

  ppr_pkg::parse_state_t           parse_state;
  logic [ppr_pkg::CNT_W-1:0]       consumed_count;
  logic [ppr_pkg::BCNT_W-1:0]      bracket_chars;
  logic                            cterm_seen;
  logic [LEN_W-1:0]                stored_length;
  logic [LEN_W-1:0]                rd_ptr;
  logic [7:0]                      e1_hold;
  logic [7:0]                      rdata;
  logic [7:0]                      mem [BUF_DEPTH];

  ppr_pkg::parse_state_t nxt;
  logic [1:0]            k;
  logic [7:0]            e0, e1;
  logic                  set_br, set_ct, in_br;
  logic                  fail;
  logic                  accepted;
  logic [LEN_W:0]        fill_sum;
  logic [ppr_pkg::EXT_W-1:0] sl_ext, bc_ext;
  logic [LEN_W-1:0]      keep;
  logic                  we;
  logic [7:0]            wdata;
  logic [7:0]            char_next;

  always_comb begin
    k      = 2'd0;
    e0     = ppr_pkg::CH_NUL;
    e1     = ppr_pkg::CH_NUL;
    nxt    = ppr_pkg::PS_ERR;
    set_br = 1'b0;
    set_ct = 1'b0;
    in_br  = 1'b0;
    unique case (parse_state)
      ppr_pkg::PS_START, ppr_pkg::PS_AFTER_CARET: begin
        if (symbol == ppr_pkg::CH_LT) begin
          if (parse_state == ppr_pkg::PS_START) begin
            k  = 2'd1;
            e0 = ppr_pkg::CH_CARET;
          end
          nxt = ppr_pkg::PS_AFTER_CARET;
        end else if (symbol == ppr_pkg::CH_LBRK) begin
          k = 2'd1; e0 = ppr_pkg::CH_LBRK; nxt = ppr_pkg::PS_BR_OPEN; set_br = 1'b1;
        end else if (symbol == ppr_pkg::CH_LBRC) begin
          k = 2'd2; e0 = ppr_pkg::CH_LBRK; e1 = ppr_pkg::CH_CARET;
          nxt = ppr_pkg::PS_NEG_OPEN;
        end else if (symbol == ppr_pkg::CH_X) begin
          k = 2'd1; e0 = ppr_pkg::CH_DOT; nxt = ppr_pkg::PS_ATOM;
        end else if (ppr_pkg::is_residue(symbol)) begin
          k = 2'd1; e0 = symbol; nxt = ppr_pkg::PS_ATOM;
        end
      end
      ppr_pkg::PS_ATOM: begin
        if (symbol == ppr_pkg::CH_DOT) begin
          nxt = ppr_pkg::PS_DONE;
        end else if (symbol == ppr_pkg::CH_DASH) begin
          nxt = ppr_pkg::PS_START;
        end else if (symbol == ppr_pkg::CH_LPAR) begin
          k = 2'd1; e0 = ppr_pkg::CH_LBRC; nxt = ppr_pkg::PS_REP_OPEN;
        end else if (symbol == ppr_pkg::CH_GT) begin
          k = 2'd1; e0 = ppr_pkg::CH_DOLLAR; nxt = ppr_pkg::PS_AFTER_DOLLAR;
        end
      end
      ppr_pkg::PS_AFTER_DOLLAR: begin
        if (symbol == ppr_pkg::CH_DOT) nxt = ppr_pkg::PS_DONE;
        else if (symbol == ppr_pkg::CH_GT) nxt = ppr_pkg::PS_AFTER_DOLLAR;
      end
      ppr_pkg::PS_BR_OPEN, ppr_pkg::PS_BR_IN, ppr_pkg::PS_BR_CTERM: begin
        in_br = 1'b1;
        if (symbol == ppr_pkg::CH_GT) begin
          set_ct = 1'b1; nxt = ppr_pkg::PS_BR_CTERM;
        end else if (ppr_pkg::is_residue(symbol)) begin
          k  = 2'd1;
          e0 = symbol;
          nxt = (parse_state == ppr_pkg::PS_BR_OPEN) ? ppr_pkg::PS_BR_IN : parse_state;
        end else if (symbol == ppr_pkg::CH_RBRK && parse_state != ppr_pkg::PS_BR_OPEN) begin
          k  = 2'd1;
          e0 = ppr_pkg::CH_RBRK;
          nxt = (parse_state == ppr_pkg::PS_BR_CTERM) ? ppr_pkg::PS_BR_DONE
                                                       : ppr_pkg::PS_ATOM;
        end
      end
      ppr_pkg::PS_BR_DONE: begin
        if (symbol == ppr_pkg::CH_DOT) nxt = ppr_pkg::PS_DONE;
      end
      ppr_pkg::PS_NEG_OPEN, ppr_pkg::PS_NEG_IN: begin
        if (ppr_pkg::is_residue(symbol)) begin
          k = 2'd1; e0 = symbol; nxt = ppr_pkg::PS_NEG_IN;
        end else if (symbol == ppr_pkg::CH_RBRC && parse_state == ppr_pkg::PS_NEG_IN) begin
          k = 2'd1; e0 = ppr_pkg::CH_RBRK; nxt = ppr_pkg::PS_ATOM;
        end
      end
      ppr_pkg::PS_REP_OPEN, ppr_pkg::PS_REP_COMMA: begin
        if (ppr_pkg::is_digit(symbol)) begin
          k  = 2'd1;
          e0 = symbol;
          nxt = (parse_state == ppr_pkg::PS_REP_OPEN) ? ppr_pkg::PS_REP_LO
                                                       : ppr_pkg::PS_REP_HI;
        end
      end
      ppr_pkg::PS_REP_LO, ppr_pkg::PS_REP_HI: begin
        if (ppr_pkg::is_digit(symbol)) begin
          k = 2'd1; e0 = symbol; nxt = parse_state;
        end else if (symbol == ppr_pkg::CH_RPAR) begin
          k = 2'd1; e0 = ppr_pkg::CH_RBRC; nxt = ppr_pkg::PS_ATOM;
        end else if (symbol == ppr_pkg::CH_COMMA && parse_state == ppr_pkg::PS_REP_LO) begin
          k = 2'd1; e0 = ppr_pkg::CH_COMMA; nxt = ppr_pkg::PS_REP_COMMA;
        end
      end
      ppr_pkg::PS_ERR, ppr_pkg::PS_DONE: begin
      end
    endcase
  end

  assign fill_sum = (LEN_W+1)'(stored_length) + (LEN_W+1)'(k);
  assign fail     = nxt == ppr_pkg::PS_ERR || fill_sum > (LEN_W+1)'(BUF_DEPTH);
  assign accepted = parse_state != ppr_pkg::PS_ERR && !fail;

  assign sl_ext = ppr_pkg::EXT_W'(stored_length);
  assign bc_ext = ppr_pkg::EXT_W'(bracket_chars);
  assign keep   = (sl_ext > bc_ext) ? LEN_W'(sl_ext - bc_ext) : '0;

  assign sts.emit_cnt  = accepted ? k : 2'd0;
  assign sts.replay    = cterm_seen && (parse_state == ppr_pkg::PS_DONE ||
                                        parse_state == ppr_pkg::PS_BR_DONE);
  assign sts.more      = rd_ptr < keep;
  assign sts.slot_free = !out_valid || out_ready;

  // store write: first character on the step, second on its own beat
  assign we    = (cmd.step && accepted && k != 2'd0) || cmd.push == ppr_pkg::PUSH_E1;
  assign wdata = (cmd.push == ppr_pkg::PUSH_E1) ? e1_hold : e0;

  always_ff @(posedge clk) begin
    if (we) mem[stored_length[ADDR_W-1:0]] <= wdata;
    if (cmd.rd) rdata <= mem[rd_ptr[ADDR_W-1:0]];
    if (cmd.step) e1_hold <= e1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.push == ppr_pkg::PUSH_TERM) begin
      parse_state    <= ppr_pkg::PS_START;
      consumed_count <= '0;
      bracket_chars  <= '0;
      cterm_seen     <= 1'b0;
      stored_length  <= '0;
      rd_ptr         <= '0;
    end else begin
      if (cmd.step && parse_state != ppr_pkg::PS_ERR) begin
        if (consumed_count != ppr_pkg::CNT_MAX) consumed_count <= consumed_count + 1'b1;
        if (fail) begin
          parse_state <= ppr_pkg::PS_ERR;
        end else begin
          parse_state <= nxt;
          if (set_ct) cterm_seen <= 1'b1;
          if (set_br) begin
            bracket_chars <= ppr_pkg::BCNT_W'(1);
          end else if (in_br && k != 2'd0 && bracket_chars < ppr_pkg::BCNT_MAX) begin
            bracket_chars <= bracket_chars + ppr_pkg::BCNT_W'(k);
          end
          if (k != 2'd0) stored_length <= stored_length + 1'b1;
        end
      end
      if (cmd.push == ppr_pkg::PUSH_E1) stored_length <= stored_length + 1'b1;
      if (cmd.push == ppr_pkg::PUSH_MEM) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_comb begin
    unique case (cmd.push)
      ppr_pkg::PUSH_E0:     char_next = e0;
      ppr_pkg::PUSH_E1:     char_next = e1_hold;
      ppr_pkg::PUSH_BAR:    char_next = ppr_pkg::CH_BAR;
      ppr_pkg::PUSH_MEM:    char_next = rdata;
      ppr_pkg::PUSH_DOLLAR: char_next = ppr_pkg::CH_DOLLAR;
      default:              char_next = ppr_pkg::CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push != ppr_pkg::PUSH_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push != ppr_pkg::PUSH_NONE) begin
      out_char <= char_next;
      is_last  <= cmd.push == ppr_pkg::PUSH_TERM;
      if (cmd.push == ppr_pkg::PUSH_TERM && !(parse_state == ppr_pkg::PS_ATOM ||
          parse_state == ppr_pkg::PS_DONE || parse_state == ppr_pkg::PS_BR_DONE)) begin
        status         <= 1'b1;
        error_position <= consumed_count;
      end else begin
        status         <= 1'b0;
        error_position <= '0;
      end
    end
  end

endmodule

[hw/rtl/ppr_ctrl.sv]
// ppr_ctrl: sequencer for character steps, second emitted character and end-marker replay.
// Depends on ppr_pkg; commands ppr_datapath.
module ppr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_end,
  output logic          in_ready,
  output ppr_pkg::cmd_t cmd,
  input  ppr_pkg::sts_t sts
);

  ppr_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ppr_pkg::CS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.step   = 1'b0;
    cmd.rd     = 1'b0;
    cmd.push   = ppr_pkg::PUSH_NONE;
    unique case (state)
      ppr_pkg::CS_IDLE: begin
        in_ready = sts.slot_free;
        if (in_valid && sts.slot_free) begin
          if (in_end) begin
            if (sts.replay) begin
              cmd.push   = ppr_pkg::PUSH_BAR;
              state_next = ppr_pkg::CS_RD_ISSUE;
            end else begin
              state_next = ppr_pkg::CS_TERM;
            end
          end else begin
            cmd.step = 1'b1;
            if (sts.emit_cnt != 2'd0) cmd.push = ppr_pkg::PUSH_E0;
            if (sts.emit_cnt == 2'd2) state_next = ppr_pkg::CS_EMIT2;
          end
        end
      end
      ppr_pkg::CS_EMIT2: begin
        if (sts.slot_free) begin
          cmd.push   = ppr_pkg::PUSH_E1;
          state_next = ppr_pkg::CS_IDLE;
        end
      end
      ppr_pkg::CS_RD_ISSUE: begin
        if (sts.more) begin
          cmd.rd     = 1'b1;
          state_next = ppr_pkg::CS_RD_WAIT;
        end else begin
          state_next = ppr_pkg::CS_DOLLAR;
        end
      end
      ppr_pkg::CS_RD_WAIT: begin
        if (sts.slot_free) begin
          cmd.push   = ppr_pkg::PUSH_MEM;
          state_next = ppr_pkg::CS_RD_ISSUE;
        end
      end
      ppr_pkg::CS_DOLLAR: begin
        if (sts.slot_free) begin
          cmd.push   = ppr_pkg::PUSH_DOLLAR;
          state_next = ppr_pkg::CS_TERM;
        end
      end
      ppr_pkg::CS_TERM: begin
        if (sts.slot_free) begin
          cmd.push   = ppr_pkg::PUSH_TERM;
          state_next = ppr_pkg::CS_IDLE;
        end
      end
      default: state_next = ppr_pkg::CS_IDLE;
    endcase
  end

endmodule

[hw/rtl/prosite_pattern_to_regex.sv]
// prosite_pattern_to_regex: top level of the motif pattern to regex translator.
// Depends on ppr_pkg, ppr_intf, ppr_ctrl and ppr_datapath.
//
//  channel   dir  beat payload                                   handshake
//  pattern   in   symbol[7:0], end_of_pattern                    valid/ready
//  regex     out  out_char[7:0], is_last, status, error_position valid/ready
//
// A '{' emits two characters; the second goes out from state CS_EMIT2.
// The end marker sends the terminator, after a bar, the replayed characters
// and '$' if a '>' sat in the final class; replay reads are registered.
// Reset is synchronous; the output store is not cleared and needs no sweep.
// A stalled regex beat holds in the output register; pattern is taken only
// while that register is empty or being drained.
module prosite_pattern_to_regex #(
  parameter int BUF_DEPTH = ppr_pkg::BUF_DEPTH_DEF
) (
  input logic            clk,
  input logic            rst,
  ppr_pattern_if.sink    pattern,
  ppr_regex_if.source    regex
);

  ppr_pkg::cmd_t cmd;
  ppr_pkg::sts_t sts;

  ppr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pattern.valid),
    .in_end   (pattern.end_of_pattern),
    .in_ready (pattern.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ppr_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .symbol         (pattern.symbol),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (regex.valid),
    .out_ready      (regex.ready),
    .out_char       (regex.out_char),
    .is_last        (regex.is_last),
    .status         (regex.status),
    .error_position (regex.error_position)
  );

endmodule

[hw/rtl/ppr_checker.sv]
// ppr_checker: port-level assertions on the regex channel of the translator.
// Depends on nothing; bound to prosite_pattern_to_regex below.
module ppr_checker (
  input logic        clk,
  input logic        rst,
  input logic        r_valid,
  input logic        r_ready,
  input logic [7:0]  r_char,
  input logic        r_last,
  input logic        r_status,
  input logic [15:0] r_pos
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_char) && $stable(r_last))
    else $error("regex beat dropped or changed while stalled");

  a_term_char: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_last |-> r_char == 8'h00)
    else $error("terminator carries a character");

  a_plain_status: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_last |-> !r_status && r_pos == 16'h0000 && r_char != 8'h00)
    else $error("character beat with status, position or null character");

  a_accept_pos: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_last && !r_status |-> r_pos == 16'h0000)
    else $error("accepted pattern reports an error position");

endmodule

bind prosite_pattern_to_regex ppr_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .r_valid  (regex.valid),
  .r_ready  (regex.ready),
  .r_char   (regex.out_char),
  .r_last   (regex.is_last),
  .r_status (regex.status),
  .r_pos    (regex.error_position)
);
